FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the tokenizer RTL.
// Each macro takes a label, the clock, the active-low reset and the checked terms.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/lft_pkg.sv
// Types and constants for the logic formula tokenizer.
// Used by every module of the block but lft_queue; depends on nothing.
`timescale 1ns / 1ps

package lft_pkg;

  // Token codes of the result channel
  typedef enum logic [3:0] {
    KIND_VAR   = 4'd0,
    KIND_TRUE  = 4'd1,
    KIND_FALSE = 4'd2,
    KIND_NEG   = 4'd3,
    KIND_AND   = 4'd4,
    KIND_OR    = 4'd5,
    KIND_IMPL  = 4'd6,
    KIND_END   = 4'd7,
    KIND_ERR   = 4'd8
  } token_kind_t;

  // Character classes handed from the front to the back
  typedef enum logic [2:0] {
    CLS_SKIP,
    CLS_NEWLINE,
    CLS_HASH,
    CLS_TOKEN,
    CLS_DIGIT,
    CLS_OTHER,
    CLS_EOI
  } char_class_t;

  // Characters the lexer knows
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_GT    = 8'h3E;

  typedef struct packed {
    logic [7:0] character;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    token_kind_t token_kind;
    logic [15:0] variable_number;
    logic [15:0] line_number;
    logic [15:0] column_number;
    logic        last;
  } out_item_t;

  // Classified character as queued between front and back
  typedef struct packed {
    char_class_t cls;
    token_kind_t kind;
    logic [3:0]  digit;
  } cls_item_t;

  // Results that the back writes into the output buffer together
  typedef struct packed {
    logic [1:0] num;
    out_item_t  first;
    out_item_t  second;
  } res_push_t;

endpackage

FILE: rtl/core/lft_front.sv
// Front of the tokenizer: takes input requests and classifies each character.
// Depends on lft_pkg; feeds lft_queue.
`timescale 1ns / 1ps

module lft_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  lft_pkg::in_item_t in_data,
  output logic              q_push,
  output lft_pkg::cls_item_t q_data,
  input  logic              q_ready
);
  import lft_pkg::*;

  // Handshake goes straight to the queue
  assign in_ready = q_ready;
  assign q_push   = in_valid && q_ready;

  // Character decoder
  always_comb begin
    q_data.kind  = KIND_ERR;
    q_data.digit = in_data.character[3:0];
    q_data.cls   = CLS_OTHER;
    if (in_data.end_of_input) begin
      q_data.cls = CLS_EOI;
    end else begin
      unique case (in_data.character) inside
        CH_SPACE, CH_TAB:   q_data.cls = CLS_SKIP;
        CH_NL:              q_data.cls = CLS_NEWLINE;
        CH_HASH:            q_data.cls = CLS_HASH;
        CH_T: begin
          q_data.cls  = CLS_TOKEN;
          q_data.kind = KIND_TRUE;
        end
        CH_F: begin
          q_data.cls  = CLS_TOKEN;
          q_data.kind = KIND_FALSE;
        end
        CH_MINUS: begin
          q_data.cls  = CLS_TOKEN;
          q_data.kind = KIND_NEG;
        end
        CH_AMP: begin
          q_data.cls  = CLS_TOKEN;
          q_data.kind = KIND_AND;
        end
        CH_BAR: begin
          q_data.cls  = CLS_TOKEN;
          q_data.kind = KIND_OR;
        end
        CH_GT: begin
          q_data.cls  = CLS_TOKEN;
          q_data.kind = KIND_IMPL;
        end
        [CH_ZERO:CH_NINE]:  q_data.cls = CLS_DIGIT;
        default:            q_data.cls = CLS_OTHER;
      endcase
    end
  end

endmodule

FILE: rtl/core/lft_queue.sv
// Small FIFO that decouples the tokenizer front from the back.
// Generic data vector; depends on nothing.
`timescale 1ns / 1ps

module lft_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             ready,
  output logic             valid,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data
);
  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PtrW-1:0]  wptr_r, wptr_nxt;
  logic [PtrW-1:0]  rptr_r, rptr_nxt;
  logic [CntW-1:0]  count_r, count_nxt;

  assign ready    = count_r != CntW'(DEPTH);
  assign valid    = count_r != '0;
  assign pop_data = mem_r[rptr_r];

  // Pointer and fill count
  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == PtrW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PtrW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/core/lft_back.sv
// Back of the tokenizer: lexer modes, number accumulation and line/column counting.
// Depends on lft_pkg and assert_macros.svh; writes results into lft_obuf.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lft_back #(
  parameter int VALUE_BITS    = 16,
  parameter int POSITION_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  lft_pkg::cls_item_t  q_data,
  output logic                pop,
  input  logic                room_two,
  output lft_pkg::res_push_t  push
);
  import lft_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_COMMENT,
    MODE_NUMBER,
    MODE_STOPPED
  } mode_t;

  localparam int SumW = VALUE_BITS + 4;

  mode_t                    mode_r, mode_nxt;
  logic [VALUE_BITS-1:0]    acc_r, acc_nxt;
  logic [POSITION_BITS-1:0] line_r, line_nxt;
  logic [POSITION_BITS-1:0] col_r, col_nxt;
  logic [POSITION_BITS-1:0] tsl_r, tsl_nxt;
  logic [POSITION_BITS-1:0] tsc_r, tsc_nxt;

  logic [POSITION_BITS-1:0] line_step, col_step;
  logic [SumW-1:0]          sum;
  logic                     overflow;
  logic                     idle_go;
  logic                     var_v, tok_v;
  out_item_t                var_res, tok_res;

  function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] x);
    sat_inc = (&x) ? x : x + 1'b1;
  endfunction

  // One character per cycle whenever the buffer can take two results
  assign pop = q_valid && room_two;

  assign line_step = sat_inc(line_r);
  assign col_step  = sat_inc(col_r);

  // acc * 10 + digit, with room to spot overflow
  assign sum = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + SumW'(q_data.digit);
  assign overflow = |sum[SumW-1:VALUE_BITS];

  // Pending number as a variable token
  always_comb begin
    var_res.token_kind      = KIND_VAR;
    var_res.variable_number = 16'(acc_r);
    var_res.line_number     = 16'(tsl_r);
    var_res.column_number   = 16'(tsc_r);
    var_res.last            = !tok_v;
  end

  // Lexer step
  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    line_nxt = line_r;
    col_nxt  = col_r;
    tsl_nxt  = tsl_r;
    tsc_nxt  = tsc_r;
    idle_go  = 1'b0;
    var_v    = 1'b0;
    tok_v    = 1'b0;
    tok_res.token_kind      = KIND_ERR;
    tok_res.variable_number = '0;
    tok_res.line_number     = 16'(line_r);
    tok_res.column_number   = 16'(col_step);
    tok_res.last            = 1'b1;

    if (pop && mode_r != MODE_STOPPED) begin
      if (q_data.cls == CLS_EOI) begin
        // Flush a pending number, then the end token one past the last column
        var_v              = mode_r == MODE_NUMBER;
        tok_v              = 1'b1;
        tok_res.token_kind = KIND_END;
        mode_nxt           = MODE_STOPPED;
      end else begin
        col_nxt = col_step;
        unique case (mode_r)
          MODE_COMMENT: begin
            if (q_data.cls == CLS_NEWLINE) begin
              mode_nxt = MODE_IDLE;
            end
          end
          MODE_NUMBER: begin
            if (q_data.cls == CLS_DIGIT) begin
              if (overflow) begin
                tok_v    = 1'b1;
                mode_nxt = MODE_STOPPED;
              end else begin
                acc_nxt = sum[VALUE_BITS-1:0];
              end
            end else begin
              // Non-digit closes the number and starts the next token
              var_v    = 1'b1;
              acc_nxt  = '0;
              mode_nxt = MODE_IDLE;
              idle_go  = 1'b1;
            end
          end
          MODE_IDLE:    idle_go = 1'b1;
          MODE_STOPPED: idle_go = 1'b0;
          default:      idle_go = 1'b0;
        endcase

        if (idle_go) begin
          case (q_data.cls) inside
            CLS_SKIP, CLS_NEWLINE: ;
            CLS_HASH: mode_nxt = MODE_COMMENT;
            CLS_TOKEN: begin
              tok_v              = 1'b1;
              tok_res.token_kind = q_data.kind;
            end
            CLS_DIGIT: begin
              if (q_data.digit != 4'd0) begin
                mode_nxt = MODE_NUMBER;
                acc_nxt  = VALUE_BITS'(q_data.digit);
                tsl_nxt  = line_r;
                tsc_nxt  = col_step;
              end else begin
                // Leading zero
                tok_v    = 1'b1;
                mode_nxt = MODE_STOPPED;
              end
            end
            default: begin
              tok_v    = 1'b1;
              mode_nxt = MODE_STOPPED;
            end
          endcase
        end

        if (q_data.cls == CLS_NEWLINE && mode_nxt != MODE_STOPPED) begin
          col_nxt  = '0;
          line_nxt = line_step;
        end
      end
    end
  end

  // Results in order: variable first, then the token of this character
  always_comb begin
    push.num    = 2'(var_v) + 2'(tok_v);
    push.first  = var_v ? var_res : tok_res;
    push.second = tok_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      acc_r  <= '0;
      line_r <= POSITION_BITS'(1);
      col_r  <= '0;
      tsl_r  <= POSITION_BITS'(1);
      tsc_r  <= '0;
    end else begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      line_r <= line_nxt;
      col_r  <= col_nxt;
      tsl_r  <= tsl_nxt;
      tsc_r  <= tsc_nxt;
    end
  end

  `ASSERT_NEXT(a_stop_holds, clk, rst_n, mode_r == MODE_STOPPED, mode_r == MODE_STOPPED)
  `ASSERT_IMPL(a_push_room, clk, rst_n, push.num != 2'd0, room_two)
  `ASSERT_IMPL(a_number_nonzero, clk, rst_n, mode_r == MODE_NUMBER, acc_r != '0)

endmodule

FILE: rtl/core/lft_obuf.sv
// Result buffer of the tokenizer: takes up to two results a cycle, gives one while out_ready is high.
// Depends on lft_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lft_obuf (
  input  logic                clk,
  input  logic                rst_n,
  input  lft_pkg::res_push_t  push,
  output logic                room_two,
  output logic                out_valid,
  input  logic                out_ready,
  output lft_pkg::out_item_t  out_data
);
  import lft_pkg::*;

  localparam int Depth = 4;

  out_item_t  mem_r [Depth];
  logic [1:0] wptr_r, wptr_nxt;
  logic [1:0] rptr_r, rptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic       pop;

  assign out_valid = count_r != 3'd0;
  assign out_data  = mem_r[rptr_r];
  assign pop       = out_valid && out_ready;
  assign room_two  = count_r <= 3'(Depth - 2);

  // Pointers wrap naturally at four entries
  always_comb begin
    wptr_nxt  = wptr_r + push.num;
    rptr_nxt  = rptr_r + 2'(pop);
    count_nxt = count_r + 3'(push.num) - 3'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem_r[wptr_r] <= push.first;
    end
    if (push.num == 2'd2) begin
      mem_r[wptr_r + 2'd1] <= push.second;
    end
  end

  `ASSERT_ALWAYS(a_obuf_bound, clk, rst_n, count_r <= 3'(Depth))
  `ASSERT_IMPL(a_obuf_two, clk, rst_n, push.num == 2'd2, count_r <= 3'(Depth - 2))

endmodule

FILE: rtl/core/logic_formula_tokenizer_unit.sv
// Tokenizer for propositional formulas, one character per request.
// A character waits in lft_queue, its results in lft_obuf, before they can be taken.
// Throughput: one character per cycle while lft_obuf has room for two results;
// a character closing a number and starting a token gives two, sent one at a time.
// Reset (rst_n, synchronous): queues empty, lexer between tokens, line 1, column 0.
// Depends on lft_pkg, lft_front, lft_queue, lft_back and lft_obuf.
`timescale 1ns / 1ps

module logic_formula_tokenizer_unit #(
  parameter int VALUE_BITS    = 16,
  parameter int POSITION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lft_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output lft_pkg::out_item_t out_data
);
  import lft_pkg::*;

  localparam int ClsW   = $bits(cls_item_t);
  localparam int QDepth = 2;

  logic      q_push, q_ready, q_valid, q_pop, room_two;
  cls_item_t q_in, q_out;
  res_push_t push;

  lft_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_data   (q_in),
    .q_ready  (q_ready)
  );

  lft_queue #(
    .WIDTH (ClsW),
    .DEPTH (QDepth)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .ready     (q_ready),
    .valid     (q_valid),
    .pop       (q_pop),
    .pop_data  (q_out)
  );

  lft_back #(
    .VALUE_BITS    (VALUE_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_data   (q_out),
    .pop      (q_pop),
    .room_two (room_two),
    .push     (push)
  );

  lft_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room_two  (room_two),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
